// ----- src/ray_sphere_nearest_pick_defines.svh -----
// Assertion helpers for the checker of this block.
`ifndef RAY_SPHERE_NEAREST_PICK_DEFINES_SVH
`define RAY_SPHERE_NEAREST_PICK_DEFINES_SVH

// Checked only while out of reset.
`define RSNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RSNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rsnp_pkg.sv -----
package rsnp_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 2;   // sum of three squared differences
  localparam int DOT_W   = SQ_W + 1;          // signed dot product
  localparam int PROD_W  = 2 * SQ_W;
  localparam int RSQ_W   = 32;
  localparam int INDEX_W = 10;
  localparam int DIST_W  = 36;
  localparam int INDEX_CAP = (1 << INDEX_W) - 1;

  localparam int MAX_SPHERES_DEF = 1024;

  // power of two: pointers wrap on their own
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 3'd6;

  localparam logic [COORD_W-1:0] NEAR_RST  = 16'h0000;
  localparam logic [COORD_W-1:0] FAR_XY_RST = 16'h0000;
  localparam logic [COORD_W-1:0] FAR_Z_RST = 16'hFF00;  // -1.0
  localparam logic [RSQ_W-1:0]   RSQ_RST   = 32'd5898; // 0.3 squared

  typedef struct packed {
    logic            hit;
    logic [SQ_W-1:0] sq_dist;
    logic            last;
  } rsnp_item_t;

endpackage

// ----- src/rsnp_front.sv -----
module rsnp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  logic [rsnp_pkg::COORD_W-1:0]  center_x,
  input  logic [rsnp_pkg::COORD_W-1:0]  center_y,
  input  logic [rsnp_pkg::COORD_W-1:0]  center_z,
  input  logic                          last_sphere,
  input  logic [rsnp_pkg::COORD_W-1:0]  near_x,
  input  logic [rsnp_pkg::COORD_W-1:0]  near_y,
  input  logic [rsnp_pkg::COORD_W-1:0]  near_z,
  input  logic [rsnp_pkg::COORD_W-1:0]  far_x,
  input  logic [rsnp_pkg::COORD_W-1:0]  far_y,
  input  logic [rsnp_pkg::COORD_W-1:0]  far_z,
  input  logic [rsnp_pkg::RSQ_W-1:0]    radius_squared,
  output logic                          push,
  output rsnp_pkg::rsnp_item_t          push_item
);

  localparam int DW = rsnp_pkg::DIFF_W;
  localparam int SW = rsnp_pkg::SQ_W;
  localparam int PW = rsnp_pkg::DOT_W;
  localparam int MW = rsnp_pkg::PROD_W;

  // ray direction, follows the config registers
  logic signed [DW-1:0] rx_r, ry_r, rz_r;
  logic [SW-1:0]        a_r;
  logic signed [SW-1:0] sq_rx, sq_ry, sq_rz;

  // stage 1: differences
  logic                 v1_r, last1_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  // stage 2: dot products
  logic                 v2_r, last2_r;
  logic [SW-1:0]        d2_r, d2_nxt;
  logic signed [PW-1:0] p_r, p_nxt;
  logic signed [SW-1:0] sq_dx, sq_dy, sq_dz;
  logic signed [PW-1:0] pr_x, pr_y, pr_z;
  // stage 3: discriminant products
  logic                 v3_r, last3_r;
  logic [SW-1:0]        d2b_r;
  logic [MW-1:0]        pp_r, ar_r, pp_nxt, ar_nxt;
  logic                 lt_r, eq_r, anz_r, pnz_r;
  logic [PW-1:0]        p_neg;
  logic [SW-1:0]        abs_p, rsq_ext, diff;
  logic                 hit;

  always_ff @(posedge clk) begin
    rx_r <= {near_x[15], near_x} - {far_x[15], far_x};
    ry_r <= {near_y[15], near_y} - {far_y[15], far_y};
    rz_r <= {near_z[15], near_z} - {far_z[15], far_z};
    a_r  <= $unsigned(sq_rx) + $unsigned(sq_ry) + $unsigned(sq_rz);
  end

  assign sq_rx = rx_r * rx_r;
  assign sq_ry = ry_r * ry_r;
  assign sq_rz = rz_r * rz_r;

  always_ff @(posedge clk) begin
    dx_r <= {near_x[15], near_x} - {center_x[15], center_x};
    dy_r <= {near_y[15], near_y} - {center_y[15], center_y};
    dz_r <= {near_z[15], near_z} - {center_z[15], center_z};
    last1_r <= last_sphere;
  end

  assign sq_dx = dx_r * dx_r;
  assign sq_dy = dy_r * dy_r;
  assign sq_dz = dz_r * dz_r;
  assign pr_x  = rx_r * dx_r;
  assign pr_y  = ry_r * dy_r;
  assign pr_z  = rz_r * dz_r;
  assign d2_nxt = $unsigned(sq_dx) + $unsigned(sq_dy) + $unsigned(sq_dz);
  assign p_nxt  = pr_x + pr_y + pr_z;

  always_ff @(posedge clk) begin
    d2_r    <= d2_nxt;
    p_r     <= p_nxt;
    last2_r <= last1_r;
  end

  assign p_neg   = PW'(-p_r);
  assign abs_p   = p_r[PW-1] ? p_neg[SW-1:0] : p_r[SW-1:0];
  assign rsq_ext = SW'(radius_squared);
  assign diff    = d2_r - rsq_ext;
  assign pp_nxt  = MW'(abs_p) * MW'(abs_p);
  assign ar_nxt  = MW'(a_r) * MW'(diff);

  always_ff @(posedge clk) begin
    pp_r    <= pp_nxt;
    ar_r    <= ar_nxt;
    lt_r    <= d2_r < rsq_ext;
    eq_r    <= d2_r == rsq_ext;
    anz_r   <= a_r != '0;
    pnz_r   <= p_r != '0;
    d2b_r   <= d2_r;
    last3_r <= last2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= item_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // inside the sphere any real ray hits; on the surface it must not be tangent
  always_comb begin
    priority if (lt_r) begin
      hit = anz_r;
    end else if (eq_r) begin
      hit = pnz_r;
    end else begin
      hit = pp_r > ar_r;
    end
  end

  assign push              = v3_r;
  assign push_item.hit     = hit;
  assign push_item.sq_dist = d2b_r;
  assign push_item.last    = last3_r;

endmodule

// ----- src/rsnp_queue.sv -----
module rsnp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rsnp_pkg::rsnp_item_t push_item,
  input  logic                 pop,
  output logic                 not_empty,
  output rsnp_pkg::rsnp_item_t head_item
);

  rsnp_pkg::rsnp_item_t mem [rsnp_pkg::QUEUE_DEPTH];
  logic [rsnp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rsnp_pkg::QCNT_W-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign not_empty = count_r != '0;
  assign head_item = mem[rd_ptr_r];

endmodule

// ----- src/rsnp_back.sv -----
module rsnp_back #(
  parameter int MAX_SPHERES = rsnp_pkg::MAX_SPHERES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rsnp_pkg::rsnp_item_t          q_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit_found,
  output logic [rsnp_pkg::INDEX_W-1:0]  hit_index,
  output logic [rsnp_pkg::DIST_W-1:0]   hit_distance
);

  localparam int LIMIT_INT = (MAX_SPHERES - 1 > rsnp_pkg::INDEX_CAP) ?
                             rsnp_pkg::INDEX_CAP : MAX_SPHERES - 1;
  localparam logic [rsnp_pkg::INDEX_W-1:0] IDX_LIMIT = rsnp_pkg::INDEX_W'(LIMIT_INT);

  logic                            best_valid_r, best_valid_nxt;
  logic [rsnp_pkg::INDEX_W-1:0]    best_index_r, best_index_nxt;
  logic [rsnp_pkg::SQ_W-1:0]       best_dist_r, best_dist_nxt;
  logic [rsnp_pkg::INDEX_W-1:0]    counter_r;
  logic                            out_valid_r;
  logic                            found_r;
  logic [rsnp_pkg::INDEX_W-1:0]    index_r;
  logic [rsnp_pkg::DIST_W-1:0]     dist_r;
  logic                            take;

  assign pop  = q_valid && (!out_valid_r || out_ready);
  // ties go to the later sphere
  assign take = q_item.hit && (!best_valid_r || q_item.sq_dist <= best_dist_r);

  assign best_valid_nxt = best_valid_r || take;
  assign best_index_nxt = take ? counter_r : best_index_r;
  assign best_dist_nxt  = take ? q_item.sq_dist : best_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_index_r <= '0;
      best_dist_r  <= '0;
      counter_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop && q_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (q_item.last) begin
          best_valid_r <= 1'b0;
          best_index_r <= '0;
          best_dist_r  <= '0;
          counter_r    <= '0;
        end else begin
          best_valid_r <= best_valid_nxt;
          best_index_r <= best_index_nxt;
          best_dist_r  <= best_dist_nxt;
          if (counter_r < IDX_LIMIT) begin
            counter_r <= counter_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      found_r <= best_valid_nxt;
      index_r <= best_valid_nxt ? best_index_nxt : '0;
      dist_r  <= best_valid_nxt ? rsnp_pkg::DIST_W'(best_dist_nxt) : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign hit_found    = found_r;
  assign hit_index    = index_r;
  assign hit_distance = dist_r;

endmodule

// ----- src/ray_sphere_nearest_pick.sv -----
// Nearest sphere hit by a pick ray.
// Input stream: one sphere centre per transfer, in_tdata = {z, y, x} in signed Q8.8,
// in_tlast marks the final sphere of a list. Config channel: cfg_index selects
// near_x, near_y, near_z, far_x, far_y, far_z, radius_squared (0..6), cfg_data
// carries the value; other indexes are dropped. cfg_ready is always high; write
// only while no list is in progress.
// Output stream: one transfer per list, after its last sphere. out_tuser is the
// hit flag, out_tdata = {pad, hit_distance (Q16.16 squared), hit_index}; index and
// distance read zero without a hit.
// Throughput: one sphere per cycle while in_tready is high. After the last sphere's
// transfer, out_tvalid follows three front stages (differences, dot products,
// discriminant products) and the pick/update step behind an 8-entry queue.
// If the receiver stalls, up to 8 spheres are taken beyond the held result, then
// in_tready drops until out_tready returns.
// Reset (rst_n low, synchronous) empties the pipeline and queue, clears the held
// hit and index counter, and loads the config defaults (far_z -1.0, r^2 0.09).
module ray_sphere_nearest_pick #(
  parameter int MAX_SPHERES = rsnp_pkg::MAX_SPHERES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // center_x, center_y, center_z
  input  logic                             in_tlast,   // last_sphere
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,  // hit_index, hit_distance, 2'b0
  output logic                             out_tuser,  // hit_found
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsnp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = rsnp_pkg::COORD_W;
  localparam int QW = rsnp_pkg::QCNT_W;

  logic [CW-1:0] near_x_r, near_y_r, near_z_r, far_x_r, far_y_r, far_z_r;
  logic [rsnp_pkg::RSQ_W-1:0] rsq_r;

  logic [QW-1:0] used_r, used_nxt;
  logic          in_acc;
  logic          push, pop, q_valid;
  rsnp_pkg::rsnp_item_t push_item, head_item;
  logic                           hit_found;
  logic [rsnp_pkg::INDEX_W-1:0]   hit_index;
  logic [rsnp_pkg::DIST_W-1:0]    hit_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_x_r <= rsnp_pkg::NEAR_RST;
      near_y_r <= rsnp_pkg::NEAR_RST;
      near_z_r <= rsnp_pkg::NEAR_RST;
      far_x_r  <= rsnp_pkg::FAR_XY_RST;
      far_y_r  <= rsnp_pkg::FAR_XY_RST;
      far_z_r  <= rsnp_pkg::FAR_Z_RST;
      rsq_r    <= rsnp_pkg::RSQ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rsnp_pkg::REG_NEAR_X:    near_x_r <= cfg_data[CW-1:0];
        rsnp_pkg::REG_NEAR_Y:    near_y_r <= cfg_data[CW-1:0];
        rsnp_pkg::REG_NEAR_Z:    near_z_r <= cfg_data[CW-1:0];
        rsnp_pkg::REG_FAR_X:     far_x_r  <= cfg_data[CW-1:0];
        rsnp_pkg::REG_FAR_Y:     far_y_r  <= cfg_data[CW-1:0];
        rsnp_pkg::REG_FAR_Z:     far_z_r  <= cfg_data[CW-1:0];
        rsnp_pkg::REG_RADIUS_SQ: rsq_r    <= cfg_data[rsnp_pkg::RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // credits cover both the front stages and the queue, so the front never stalls
  assign in_tready = used_r < QW'(rsnp_pkg::QUEUE_DEPTH);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    unique case ({in_acc, pop})
      2'b10:   used_nxt = used_r + 1'b1;
      2'b01:   used_nxt = used_r - 1'b1;
      default: used_nxt = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  rsnp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_acc),
    .center_x       (in_tdata[15:0]),
    .center_y       (in_tdata[31:16]),
    .center_z       (in_tdata[47:32]),
    .last_sphere    (in_tlast),
    .near_x         (near_x_r),
    .near_y         (near_y_r),
    .near_z         (near_z_r),
    .far_x          (far_x_r),
    .far_y          (far_y_r),
    .far_z          (far_z_r),
    .radius_squared (rsq_r),
    .push           (push),
    .push_item      (push_item)
  );

  rsnp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  rsnp_back #(
    .MAX_SPHERES (MAX_SPHERES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .hit_found    (hit_found),
    .hit_index    (hit_index),
    .hit_distance (hit_distance)
  );

  assign out_tdata = {2'b00, hit_distance, hit_index};
  assign out_tuser = hit_found;

endmodule

// ----- src/rsnp_checker.sv -----
`include "ray_sphere_nearest_pick_defines.svh"

module rsnp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [47:0]                      out_tdata,
  input logic                             out_tuser
);

  `RSNP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `RSNP_ASSERT(a_miss_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "miss result carries index or distance")
  `RSNP_ASSERT(a_dist_range, out_tvalid |-> out_tdata[47:44] == 4'b0000, "squared distance out of range")
  `RSNP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind ray_sphere_nearest_pick rsnp_checker u_rsnp_checker (.*);
